/* hdl/tcp_sender_window_retransmit_core_macros.svh */
// Assertion helpers for the block that checks itself.
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_CORE_MACROS_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_CORE_MACROS_SVH

// Check that a condition always leads to a consequence in the same cycle.
`define TSWR_ASSERT_IMPL(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds.
`define TSWR_ASSERT_NEVER(label, clock, resetn, cond, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) !(cond)) \
        else $error(msg);

`endif

/* hdl/tswr_pkg.sv */
`default_nettype none

package tswr_pkg;

    localparam int MAX_PAYLOAD_DEF  = 1024;
    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int ABS_SEQ_BITS_DEF = 40;
    localparam int RES_LIMIT        = 64;

    localparam int CAP_W      = 20;
    localparam int RTO_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 11;
    localparam int OFF_W      = 40;
    localparam int WIN_W      = 16;
    localparam int RETRY_W    = 8;
    localparam int CNT_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RTO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ISN      = 2'd2;

    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_FILL  = 3'd1;
    localparam logic [2:0] REQ_ACK   = 3'd2;
    localparam logic [2:0] REQ_TICK  = 3'd3;
    localparam logic [2:0] REQ_EMPTY = 3'd4;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_FILL,
        OP_ACK,
        OP_TICK,
        OP_EMPTY,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] byte_count;
        logic        end_input;
        logic [31:0] ack_number;
        logic [15:0] peer_window;
        logic [31:0] elapsed_ms;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_FILL_CHK,
        ST_FILL_SIM,
        ST_FILL_EMIT,
        ST_ACK_CALC,
        ST_ACK_RD,
        ST_ACK_CMP,
        ST_ACK_DONE,
        ST_TICK,
        ST_TICK_EMIT,
        ST_EMPTY,
        ST_STATUS
    } eng_state_t;

endpackage

`default_nettype wire

/* hdl/tswr_front.sv */
`default_nettype none

module tswr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        req_type,
    input  logic [15:0]       byte_count,
    input  logic              end_input,
    input  logic [31:0]       ack_number,
    input  logic [15:0]       peer_window,
    input  logic [31:0]       elapsed_ms,
    output logic              busy,
    output logic              cmd_valid,
    output tswr_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);
    import tswr_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       incoming;

    // Classify the request
    always_comb
    begin
        incoming.byte_count  = byte_count;
        incoming.end_input   = end_input;
        incoming.ack_number  = ack_number;
        incoming.peer_window = peer_window;
        incoming.elapsed_ms  = elapsed_ms;
        unique case (req_type)
            REQ_WRITE: incoming.op = OP_WRITE;
            REQ_FILL:  incoming.op = OP_FILL;
            REQ_ACK:   incoming.op = OP_ACK;
            REQ_TICK:  incoming.op = OP_TICK;
            REQ_EMPTY: incoming.op = OP_EMPTY;
            default:   incoming.op = OP_NONE;
        endcase
    end

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the transfer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

/* hdl/tswr_back.sv */
`default_nettype none

module tswr_back #(
    parameter int MAX_PAYLOAD  = tswr_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH  = tswr_pkg::QUEUE_DEPTH_DEF,
    parameter int ABS_SEQ_BITS = tswr_pkg::ABS_SEQ_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tswr_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [tswr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    input  tswr_pkg::cmd_t                    cmd,
    output logic                              cmd_pop,
    output logic                              result_valid,
    output logic                              kind,
    output logic [31:0]                       seq_number,
    output logic [tswr_pkg::LEN_W-1:0]        payload_len,
    output logic [tswr_pkg::OFF_W-1:0]        stream_offset,
    output logic                              syn_flag,
    output logic                              fin_flag,
    output logic                              is_retransmit,
    output logic [15:0]                       in_flight,
    output logic [tswr_pkg::RETRY_W-1:0]      retx_count,
    output logic                              last
);
    import tswr_pkg::*;

    localparam int ABS = ABS_SEQ_BITS;
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW  = QCW + 1;
    localparam int INFO_W = LEN_W + 2;

    eng_state_t state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [RTO_W-1:0] irto_reg, irto_next;
    logic [31:0]      isn_reg, isn_next;

    logic [ABS-1:0]     nxt_reg, nxt_next;
    logic [ABS-1:0]     una_reg, una_next;
    logic [15:0]        flight_reg, flight_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [CAP_W-1:0]   buf_reg, buf_next;
    logic               closed_reg, closed_next;
    logic               fin_sent_reg, fin_sent_next;
    logic [31:0]        rto_reg, rto_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;
    logic               trun_reg, trun_next;
    logic [31:0]        tela_reg, tela_next;
    logic [QAW-1:0]     head_reg, head_next;
    logic [QCW-1:0]     qc_reg, qc_next;

    // Scratch copy of the fill state, walked twice per fill
    logic [ABS-1:0]   s_nxt_reg, s_nxt_next;
    logic [15:0]      s_flight_reg, s_flight_next;
    logic [CAP_W-1:0] s_buf_reg, s_buf_next;
    logic             s_fin_reg, s_fin_next;
    logic [QCW-1:0]   s_qc_reg, s_qc_next;
    logic [CNT_W-1:0] s_n_reg, s_n_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [15:0]      fflight_reg, fflight_next;

    logic [ABS-1:0] acka_reg, acka_next;
    logic           ackok_reg, ackok_next;

    logic [ABS-1:0]    seq_mem [QUEUE_DEPTH];
    logic [INFO_W-1:0] info_mem [QUEUE_DEPTH];
    logic [ABS-1:0]    rd_seq_reg;
    logic [INFO_W-1:0] rd_info_reg;
    logic              mem_we;
    logic [QAW-1:0]    tail;
    logic [TW-1:0]     tail_sum;

    logic               res_valid_reg, res_valid_next;
    logic               kind_reg, kind_next;
    logic [31:0]        seq_reg, seq_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic               syn_reg, syn_next;
    logic               fin_reg, fin_next;
    logic               retx_reg, retx_next;
    logic [15:0]        infl_reg, infl_next;
    logic [RETRY_W-1:0] rcnt_reg, rcnt_next;
    logic               last_reg, last_next;

    // Fill step signals
    logic [15:0]      actual;
    logic             fill_open;
    logic             it_brk, it_syn, it_fin, it_seg, it_cont, it_end;
    logic [ABS-1:0]   nxt1, nxt2, nxt3;
    logic [15:0]      fl1, fl2, fl3, room;
    logic [CAP_W-1:0] rd20, buf2;
    logic [LEN_W-1:0] it_rd;
    logic [CNT_W-1:0] sim_total;
    logic             emit_last;

    // Ack and tick signals
    logic [31:0]    ack_off, ack_d;
    logic [32:0]    ack_back;
    logic [ABS-1:0] ack_a;
    logic           ack_ok;
    logic [11:0]    ent_len;
    logic [ABS:0]   ent_end;
    logic           ack_pop;
    logic [32:0]    tick_sum;
    logic [31:0]    tick_ela;
    logic           tick_fire;

    // Entry decode for the head of the queue
    logic           h_syn, h_fin;
    logic [ABS-1:0] h_off;
    logic [63:0]    h_off64;
    logic [ABS-1:0] s_off;
    logic [63:0]    s_off64;

    // One step of the segmenter over the scratch state
    always_comb
    begin
        actual    = (win_reg == '0) ? 16'd1 : win_reg;
        fill_open = (actual > flight_reg);
        it_brk    = s_fin_reg || (s_qc_reg >= QCW'(QUEUE_DEPTH))
                    || (s_n_reg >= CNT_W'(RES_LIMIT));
        it_syn    = (s_nxt_reg == '0);
        nxt1      = it_syn ? ABS'(1) : s_nxt_reg;
        fl1       = s_flight_reg + 16'(it_syn);
        room      = actual - fl1;
        rd20      = CAP_W'(room);
        if (rd20 > CAP_W'(MAX_PAYLOAD))
        begin
            rd20 = CAP_W'(MAX_PAYLOAD);
        end
        if (rd20 > s_buf_reg)
        begin
            rd20 = s_buf_reg;
        end
        it_rd     = LEN_W'(rd20);
        buf2      = s_buf_reg - rd20;
        fl2       = fl1 + 16'(it_rd);
        nxt2      = nxt1 + ABS'(it_rd);
        it_fin    = closed_reg && (buf2 == '0) && (actual > fl2);
        nxt3      = nxt2 + ABS'(it_fin);
        fl3       = fl2 + 16'(it_fin);
        it_seg    = (it_rd != '0) || it_syn || it_fin;
        it_cont   = (buf2 != '0) && (actual > fl3);
        it_end    = it_brk || !it_cont;
        sim_total = s_n_reg + CNT_W'(!it_brk && it_seg);
        emit_last = (CNT_W'(s_n_reg + 1'b1) == total_reg);
        tail_sum  = TW'(head_reg) + TW'(s_qc_reg);
        if (tail_sum >= TW'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - TW'(QUEUE_DEPTH);
        end
        tail      = QAW'(tail_sum);
        s_off     = (it_syn || s_nxt_reg == '0) ? '0 : s_nxt_reg - ABS'(1);
        s_off64   = 64'(s_off);
    end

    // Unwrap the ack number, walk the head entry, run the timer
    always_comb
    begin
        ack_off  = cmd_reg.ack_number - isn_reg;
        ack_d    = ack_off - nxt_reg[31:0];
        ack_back = 33'h1_0000_0000 - {1'b0, ack_d};
        if (!ack_d[31])
        begin
            ack_a = nxt_reg + ABS'(ack_d);
        end
        else if (nxt_reg >= ABS'(ack_back))
        begin
            ack_a = nxt_reg - ABS'(ack_back);
        end
        else
        begin
            ack_a = nxt_reg + ABS'(ack_d);
        end
        ack_ok   = (ack_a > una_reg) && (ack_a <= nxt_reg);
        h_syn    = rd_info_reg[LEN_W];
        h_fin    = rd_info_reg[LEN_W+1];
        ent_len  = 12'(rd_info_reg[LEN_W-1:0]) + 12'(h_syn) + 12'(h_fin);
        ent_end  = {1'b0, rd_seq_reg} + (ABS+1)'(ent_len);
        ack_pop  = ({1'b0, acka_reg} >= ent_end);
        h_off    = (h_syn || rd_seq_reg == '0) ? '0 : rd_seq_reg - ABS'(1);
        h_off64  = 64'(h_off);
        tick_sum = {1'b0, tela_reg} + {1'b0, cmd_reg.elapsed_ms};
        tick_ela = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
        tick_fire = (tick_ela >= rto_reg) && (qc_reg != '0);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_WRITE: state_next = ST_WRITE;
                        OP_FILL:  state_next = ST_FILL_CHK;
                        OP_ACK:   state_next = ST_ACK_CALC;
                        OP_TICK:  state_next = ST_TICK;
                        OP_EMPTY: state_next = ST_EMPTY;
                        default:  state_next = ST_STATUS;
                    endcase
                end
            end
            ST_WRITE:     state_next = ST_STATUS;
            ST_FILL_CHK:  state_next = fill_open ? ST_FILL_SIM : ST_IDLE;
            ST_FILL_SIM:
            begin
                if (it_end)
                begin
                    state_next = (sim_total == '0) ? ST_IDLE : ST_FILL_EMIT;
                end
            end
            ST_FILL_EMIT: state_next = emit_last ? ST_IDLE : ST_FILL_EMIT;
            ST_ACK_CALC:  state_next = ack_ok ? ST_ACK_RD : ST_ACK_DONE;
            ST_ACK_RD:    state_next = (qc_reg == '0) ? ST_ACK_DONE : ST_ACK_CMP;
            ST_ACK_CMP:   state_next = ack_pop ? ST_ACK_RD : ST_ACK_DONE;
            ST_ACK_DONE:  state_next = ST_IDLE;
            ST_TICK:      state_next = (trun_reg && tick_fire) ? ST_TICK_EMIT : ST_IDLE;
            ST_TICK_EMIT: state_next = ST_IDLE;
            ST_EMPTY:     state_next = ST_IDLE;
            ST_STATUS:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign mem_we  = (state_reg == ST_FILL_EMIT);

    // Datapath and result updates
    always_comb
    begin
        logic [CAP_W-1:0] wr_room;
        logic [CAP_W-1:0] wr_add;
        logic             emit_status;

        cmd_next      = cmd_reg;
        cap_next      = cap_reg;
        irto_next     = irto_reg;
        isn_next      = isn_reg;
        nxt_next      = nxt_reg;
        una_next      = una_reg;
        flight_next   = flight_reg;
        win_next      = win_reg;
        buf_next      = buf_reg;
        closed_next   = closed_reg;
        fin_sent_next = fin_sent_reg;
        rto_next      = rto_reg;
        retry_next    = retry_reg;
        trun_next     = trun_reg;
        tela_next     = tela_reg;
        head_next     = head_reg;
        qc_next       = qc_reg;
        s_nxt_next    = s_nxt_reg;
        s_flight_next = s_flight_reg;
        s_buf_next    = s_buf_reg;
        s_fin_next    = s_fin_reg;
        s_qc_next     = s_qc_reg;
        s_n_next      = s_n_reg;
        total_next    = total_reg;
        fflight_next  = fflight_reg;
        acka_next     = acka_reg;
        ackok_next    = ackok_reg;

        res_valid_next = 1'b0;
        kind_next      = kind_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        off_next       = off_reg;
        syn_next       = syn_reg;
        fin_next       = fin_reg;
        retx_next      = retx_reg;
        infl_next      = infl_reg;
        rcnt_next      = rcnt_reg;
        last_next      = last_reg;
        emit_status    = 1'b0;
        wr_room        = (cap_reg > buf_reg) ? cap_reg - buf_reg : '0;
        wr_add         = (CAP_W'(cmd_reg.byte_count) < wr_room)
                         ? CAP_W'(cmd_reg.byte_count) : wr_room;

        // Take configuration writes
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_CAPACITY: cap_next = cfg_data[CAP_W-1:0];
                CFG_RTO:
                begin
                    irto_next = cfg_data[RTO_W-1:0];
                    rto_next  = 32'(cfg_data[RTO_W-1:0]);
                end
                CFG_ISN:      isn_next = cfg_data;
                default:      ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                end
            end
            ST_WRITE:
            begin
                if (!closed_reg)
                begin
                    buf_next = buf_reg + wr_add;
                    if (cmd_reg.end_input)
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
            ST_FILL_CHK:
            begin
                s_nxt_next    = nxt_reg;
                s_flight_next = flight_reg;
                s_buf_next    = buf_reg;
                s_fin_next    = fin_sent_reg;
                s_qc_next     = qc_reg;
                s_n_next      = '0;
                emit_status   = !fill_open;
            end
            ST_FILL_SIM:
            begin
                // Dry run to learn the final flight size and segment count
                if (!it_brk)
                begin
                    s_nxt_next    = nxt3;
                    s_flight_next = fl3;
                    s_buf_next    = buf2;
                    s_fin_next    = s_fin_reg || it_fin;
                    s_qc_next     = s_qc_reg + QCW'(it_seg);
                    s_n_next      = s_n_reg + CNT_W'(it_seg);
                end
                if (it_end)
                begin
                    total_next    = sim_total;
                    fflight_next  = it_brk ? s_flight_reg : fl3;
                    emit_status   = (sim_total == '0);
                    s_nxt_next    = nxt_reg;
                    s_flight_next = flight_reg;
                    s_buf_next    = buf_reg;
                    s_fin_next    = fin_sent_reg;
                    s_qc_next     = qc_reg;
                    s_n_next      = '0;
                end
            end
            ST_FILL_EMIT:
            begin
                // Queue and send one segment
                s_nxt_next    = nxt3;
                s_flight_next = fl3;
                s_buf_next    = buf2;
                s_fin_next    = s_fin_reg || it_fin;
                s_qc_next     = s_qc_reg + QCW'(1);
                s_n_next      = s_n_reg + CNT_W'(1);
                res_valid_next = 1'b1;
                kind_next      = KIND_SEGMENT;
                seq_next       = isn_reg + s_nxt_reg[31:0];
                len_next       = it_rd;
                off_next       = s_off64[OFF_W-1:0];
                syn_next       = it_syn;
                fin_next       = it_fin;
                retx_next      = 1'b0;
                last_next      = emit_last;
                if (emit_last)
                begin
                    nxt_next      = nxt3;
                    flight_next   = fl3;
                    buf_next      = buf2;
                    fin_sent_next = s_fin_reg || it_fin;
                    qc_next       = s_qc_reg + QCW'(1);
                    if (!trun_reg)
                    begin
                        trun_next = 1'b1;
                        tela_next = '0;
                    end
                end
            end
            ST_ACK_CALC:
            begin
                win_next   = cmd_reg.peer_window;
                acka_next  = ack_a;
                ackok_next = ack_ok;
                if (ack_ok)
                begin
                    una_next = ack_a;
                end
            end
            ST_ACK_CMP:
            begin
                // Retire the head segment once fully acknowledged
                if (ack_pop)
                begin
                    flight_next = (flight_reg > 16'(ent_len)) ? flight_reg - 16'(ent_len) : '0;
                    head_next   = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QAW'(1);
                    qc_next     = qc_reg - QCW'(1);
                end
            end
            ST_ACK_DONE:
            begin
                if (ackok_reg)
                begin
                    rto_next   = 32'(irto_reg);
                    retry_next = '0;
                    trun_next  = (qc_reg != '0);
                    tela_next  = '0;
                end
                emit_status = 1'b1;
            end
            ST_TICK:
            begin
                if (trun_reg)
                begin
                    tela_next = tick_ela;
                end
                emit_status = !(trun_reg && tick_fire);
            end
            ST_TICK_EMIT:
            begin
                // Resend the oldest segment and, unless the peer window is zero, back off
                if (win_reg != '0)
                begin
                    if (retry_reg != '1)
                    begin
                        retry_next = retry_reg + RETRY_W'(1);
                    end
                    rto_next = rto_reg[31] ? 32'hFFFF_FFFF : {rto_reg[30:0], 1'b0};
                end
                trun_next      = 1'b1;
                tela_next      = '0;
                res_valid_next = 1'b1;
                kind_next      = KIND_SEGMENT;
                seq_next       = isn_reg + rd_seq_reg[31:0];
                len_next       = rd_info_reg[LEN_W-1:0];
                off_next       = h_off64[OFF_W-1:0];
                syn_next       = h_syn;
                fin_next       = h_fin;
                retx_next      = 1'b1;
                last_next      = 1'b1;
            end
            ST_EMPTY:
            begin
                res_valid_next = 1'b1;
                kind_next      = KIND_SEGMENT;
                seq_next       = isn_reg + nxt_reg[31:0];
                len_next       = '0;
                off_next       = '0;
                syn_next       = 1'b0;
                fin_next       = 1'b0;
                retx_next      = 1'b0;
                last_next      = 1'b1;
            end
            ST_STATUS:    emit_status = 1'b1;
            default:      ;
        endcase

        // Status-only result
        if (emit_status)
        begin
            res_valid_next = 1'b1;
            kind_next      = KIND_STATUS;
            seq_next       = '0;
            len_next       = '0;
            off_next       = '0;
            syn_next       = 1'b0;
            fin_next       = 1'b0;
            retx_next      = 1'b0;
            last_next      = 1'b1;
        end
        infl_next = (state_reg == ST_FILL_EMIT) ? fflight_reg : flight_next;
        rcnt_next = retry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_W'(65535);
            irto_reg      <= RTO_W'(1000);
            isn_reg       <= '0;
            nxt_reg       <= '0;
            una_reg       <= '0;
            flight_reg    <= '0;
            win_reg       <= WIN_W'(1);
            buf_reg       <= '0;
            closed_reg    <= 1'b0;
            fin_sent_reg  <= 1'b0;
            rto_reg       <= 32'd1000;
            retry_reg     <= '0;
            trun_reg      <= 1'b0;
            tela_reg      <= '0;
            head_reg      <= '0;
            qc_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            irto_reg      <= irto_next;
            isn_reg       <= isn_next;
            nxt_reg       <= nxt_next;
            una_reg       <= una_next;
            flight_reg    <= flight_next;
            win_reg       <= win_next;
            buf_reg       <= buf_next;
            closed_reg    <= closed_next;
            fin_sent_reg  <= fin_sent_next;
            rto_reg       <= rto_next;
            retry_reg     <= retry_next;
            trun_reg      <= trun_next;
            tela_reg      <= tela_next;
            head_reg      <= head_next;
            qc_reg        <= qc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        s_nxt_reg    <= s_nxt_next;
        s_flight_reg <= s_flight_next;
        s_buf_reg    <= s_buf_next;
        s_fin_reg    <= s_fin_next;
        s_qc_reg     <= s_qc_next;
        s_n_reg      <= s_n_next;
        total_reg    <= total_next;
        fflight_reg  <= fflight_next;
        acka_reg     <= acka_next;
        ackok_reg    <= ackok_next;
        kind_reg     <= kind_next;
        seq_reg      <= seq_next;
        len_reg      <= len_next;
        off_reg      <= off_next;
        syn_reg      <= syn_next;
        fin_reg      <= fin_next;
        retx_reg     <= retx_next;
        infl_reg     <= infl_next;
        rcnt_reg     <= rcnt_next;
        last_reg     <= last_next;
    end

    // Outstanding segment queue
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seq_mem[tail]  <= s_nxt_reg;
            info_mem[tail] <= {it_fin, it_syn, it_rd};
        end
        rd_seq_reg  <= seq_mem[head_reg];
        rd_info_reg <= info_mem[head_reg];
    end

    assign result_valid  = res_valid_reg;
    assign kind          = kind_reg;
    assign seq_number    = seq_reg;
    assign payload_len   = len_reg;
    assign stream_offset = off_reg;
    assign syn_flag      = syn_reg;
    assign fin_flag      = fin_reg;
    assign is_retransmit = retx_reg;
    assign in_flight     = infl_reg;
    assign retx_count    = rcnt_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

/* hdl/tcp_sender_window_retransmit_core.sv */
// Channel   Direction  Handshake                Payload
// command   in         start / busy             req_type, byte_count, end_input,
//                                               ack_number, peer_window, elapsed_ms
// config    in         cfg_we                   cfg_idx, cfg_data
// result    out        result_valid (1 cycle)   kind .. last
//
// A command enters a two-entry queue and is taken by the engine when it is idle;
// each result is registered and leaves in the cycle after the engine state that makes it.
// A fill makes a dry pass over its segments and then an emitting pass; an acceptable
// ack retires fully acknowledged segments from the head one by one; a tick may resend
// the oldest segment. Reset is asynchronous, active low; the queue memory needs no clearing.
// busy rises when the command queue is full; results cannot be held off.
`default_nettype none

`include "tcp_sender_window_retransmit_core_macros.svh"

module tcp_sender_window_retransmit_core #(
    parameter int MAX_PAYLOAD  = tswr_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH  = tswr_pkg::QUEUE_DEPTH_DEF,
    parameter int ABS_SEQ_BITS = tswr_pkg::ABS_SEQ_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tswr_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [tswr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        req_type,
    input  logic [15:0]                       byte_count,
    input  logic                              end_input,
    input  logic [31:0]                       ack_number,
    input  logic [15:0]                       peer_window,
    input  logic [31:0]                       elapsed_ms,
    output logic                              result_valid,
    output logic                              kind,
    output logic [31:0]                       seq_number,
    output logic [tswr_pkg::LEN_W-1:0]        payload_len,
    output logic [tswr_pkg::OFF_W-1:0]        stream_offset,
    output logic                              syn_flag,
    output logic                              fin_flag,
    output logic                              is_retransmit,
    output logic [15:0]                       in_flight,
    output logic [tswr_pkg::RETRY_W-1:0]      retx_count,
    output logic                              last
);
    import tswr_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // Accept and classify commands
    tswr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .byte_count  (byte_count),
        .end_input   (end_input),
        .ack_number  (ack_number),
        .peer_window (peer_window),
        .elapsed_ms  (elapsed_ms),
        .busy        (busy),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // Carry out commands
    tswr_back #(
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .ABS_SEQ_BITS (ABS_SEQ_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .result_valid  (result_valid),
        .kind          (kind),
        .seq_number    (seq_number),
        .payload_len   (payload_len),
        .stream_offset (stream_offset),
        .syn_flag      (syn_flag),
        .fin_flag      (fin_flag),
        .is_retransmit (is_retransmit),
        .in_flight     (in_flight),
        .retx_count    (retx_count),
        .last          (last)
    );

    `TSWR_ASSERT_IMPL(a_pop_has_cmd, clk, rst_n, cmd_pop, cmd_valid, "pop from empty command queue")
    `TSWR_ASSERT_IMPL(a_status_clean, clk, rst_n, result_valid && kind == KIND_STATUS, seq_number == '0 && payload_len == '0 && !syn_flag && !fin_flag, "status result carries segment data")
    `TSWR_ASSERT_NEVER(a_syn_offset, clk, rst_n, result_valid && syn_flag && stream_offset != '0, "SYN segment with nonzero stream offset")

endmodule

`default_nettype wire

/* sim/tswr_checker.sv */
`default_nettype none

module tswr_checker
    import tswr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  logic                  busy,
    input  logic [2:0]            req_type,
    input  logic [15:0]           byte_count,
    input  logic                  end_input,
    input  logic [31:0]           ack_number,
    input  logic [15:0]           peer_window,
    input  logic [31:0]           elapsed_ms,
    input  logic                  result_valid,
    input  logic                  kind,
    input  logic [31:0]           seq_number,
    input  logic [LEN_W-1:0]      payload_len,
    input  logic [OFF_W-1:0]      stream_offset,
    input  logic                  syn_flag,
    input  logic                  fin_flag,
    input  logic                  is_retransmit,
    input  logic [15:0]           in_flight,
    input  logic [RETRY_W-1:0]    retx_count,
    input  logic                  last,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic [31:0]       seq;
        logic [LEN_W-1:0]  len;
        logic [OFF_W-1:0]  off;
        logic              syn;
        logic              fin;
        logic              retx;
        logic [15:0]       flight;
        logic [RETRY_W-1:0] retries;
        logic              last;
    } seg_result_t;

    // Sender state mirrored from the block
    logic [31:0] capacity, init_rto, isn;
    logic [39:0] snd_nxt, snd_una;
    logic [31:0] flight, window, buffered;
    logic        closed, fin_done, timer_on;
    logic [31:0] rto, retries, timer_ms;
    logic [39:0] seg_start [QUEUE_DEPTH_DEF];
    logic [12:0] seg_info  [QUEUE_DEPTH_DEF];
    int unsigned q_head, q_count;

    seg_result_t segs_now[$];
    seg_result_t expected_results[$];

    function automatic logic [31:0] wrap_seq(logic [39:0] abs_seq);
        return isn + abs_seq[31:0];
    endfunction

    function automatic logic [39:0] unwrap_ack(logic [31:0] n);
        logic [31:0] rel, d;
        logic [63:0] back;
        rel = n - isn;
        d = rel - snd_nxt[31:0];
        if (d < 32'h8000_0000)
            return snd_nxt + {8'b0, d};
        back = 64'h1_0000_0000 - {32'b0, d};
        if ({24'b0, snd_nxt} >= back)
            return snd_nxt - back[39:0];
        return snd_nxt + {8'b0, d};
    endfunction

    task automatic push_entry(int unsigned idx, logic retx);
        seg_result_t r;
        logic [39:0] o;
        r = '0;
        r.kind = KIND_SEGMENT;
        r.seq  = wrap_seq(seg_start[idx]);
        r.len  = seg_info[idx][10:0];
        r.syn  = seg_info[idx][11];
        r.fin  = seg_info[idx][12];
        r.retx = retx;
        o = seg_start[idx] + r.syn;
        r.off = (o != 0) ? o - 1 : 0;
        segs_now.push_back(r);
    endtask

    task automatic predict_fill();
        logic [31:0] actual, room, rd;
        logic [39:0] seg_seq;
        logic        syn, fin;
        int unsigned idx;
        actual = (window != 0) ? window : 1;
        if (actual <= flight)
            return;
        while (1)
        begin
            seg_seq = snd_nxt;
            syn = 0;
            fin = 0;
            if (fin_done || q_count >= QUEUE_DEPTH_DEF || segs_now.size() >= RES_LIMIT)
                break;
            if (snd_nxt == 0)
            begin
                syn = 1;
                snd_nxt = 1;
                flight++;
            end
            room = actual - flight;
            rd = (room < MAX_PAYLOAD_DEF) ? room : MAX_PAYLOAD_DEF;
            if (rd > buffered)
                rd = buffered;
            buffered -= rd;
            flight += rd;
            snd_nxt = snd_nxt + rd;
            if (closed && buffered == 0 && actual > flight)
            begin
                fin = 1;
                snd_nxt = snd_nxt + 1;
                flight++;
                fin_done = 1;
            end
            if (rd != 0 || syn || fin)
            begin
                idx = (q_head + q_count) % QUEUE_DEPTH_DEF;
                seg_start[idx] = seg_seq;
                seg_info[idx] = {fin, syn, rd[10:0]};
                q_count++;
                push_entry(idx, 1'b0);
                if (!timer_on)
                begin
                    timer_on = 1;
                    timer_ms = 0;
                end
            end
            if (!(buffered > 0 && actual > flight))
                break;
        end
    endtask

    task automatic take_ack(logic [31:0] n, logic [15:0] win);
        logic [39:0] a;
        logic [31:0] len;
        a = unwrap_ack(n);
        window = {16'b0, win};
        if (a <= snd_una || a > snd_nxt)
            return;
        snd_una = a;
        // retire whole segments only
        while (q_count > 0)
        begin
            len = seg_info[q_head][10:0] + seg_info[q_head][11] + seg_info[q_head][12];
            if ({24'b0, a} < {24'b0, seg_start[q_head]} + len)
                break;
            flight = (flight > len) ? flight - len : 0;
            q_head = (q_head + 1) % QUEUE_DEPTH_DEF;
            q_count--;
        end
        rto = init_rto;
        retries = 0;
        timer_on = (q_count != 0);
        timer_ms = 0;
    endtask

    task automatic run_timer(logic [31:0] ms);
        logic [32:0] e;
        if (!timer_on)
            return;
        e = {1'b0, timer_ms} + {1'b0, ms};
        timer_ms = e[32] ? 32'hFFFF_FFFF : e[31:0];
        if (timer_ms < rto || q_count == 0)
            return;
        push_entry(q_head, 1'b1);
        if (window != 0)
        begin
            if (retries < 255)
                retries++;
            rto = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto << 1;
        end
        timer_ms = 0;
    endtask

    task automatic predict_command();
        seg_result_t r;
        logic [31:0] room, cnt;
        segs_now.delete();
        case (req_type)
            REQ_WRITE:
            begin
                if (!closed)
                begin
                    room = (capacity > buffered) ? capacity - buffered : 0;
                    cnt = {16'b0, byte_count};
                    buffered += (cnt < room) ? cnt : room;
                    if (end_input)
                        closed = 1;
                end
            end
            REQ_FILL: predict_fill();
            REQ_ACK:  take_ack(ack_number, peer_window);
            REQ_TICK: run_timer(elapsed_ms);
            REQ_EMPTY:
            begin
                r = '0;
                r.kind = KIND_SEGMENT;
                r.seq = wrap_seq(snd_nxt);
                segs_now.push_back(r);
            end
            default: ;
        endcase
        if (segs_now.size() == 0)
        begin
            r = '0;
            r.kind = KIND_STATUS;
            segs_now.push_back(r);
        end
        foreach (segs_now[k])
        begin
            r = segs_now[k];
            r.flight = flight[15:0];
            r.retries = retries[7:0];
            r.last = (k == segs_now.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seg_result_t e;
        if (!rst_n)
        begin
            capacity = 65535;
            init_rto = 1000;
            isn = 0;
            snd_nxt = 0;
            snd_una = 0;
            flight = 0;
            window = 1;
            buffered = 0;
            closed = 0;
            fin_done = 0;
            timer_on = 0;
            rto = 1000;
            retries = 0;
            timer_ms = 0;
            q_head = 0;
            q_count = 0;
            errors = 0;
            expected_results.delete();
        end
        else
        begin
            // apply register writes
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_CAPACITY: capacity = {12'b0, cfg_data[CAP_W-1:0]};
                    CFG_RTO:
                    begin
                        init_rto = {16'b0, cfg_data[RTO_W-1:0]};
                        rto = init_rto;
                    end
                    CFG_ISN: isn = cfg_data;
                    default: ;
                endcase
            end
            // predict each accepted command
            if (start && !busy)
                predict_command();
            // compare each result transfer against the oldest expectation
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: kind %0h seq %0h", $time, kind, seq_number);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("kind", e.kind, kind);
                    check_field("seq_number", e.seq, seq_number);
                    check_field("payload_len", e.len, payload_len);
                    check_field("stream_offset", e.off, stream_offset);
                    check_field("syn_flag", e.syn, syn_flag);
                    check_field("fin_flag", e.fin, fin_flag);
                    check_field("is_retransmit", e.retx, is_retransmit);
                    check_field("in_flight", e.flight, in_flight);
                    check_field("retx_count", e.retries, retx_count);
                    check_field("last", e.last, last);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
    import tswr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  start = 0;
    logic                  busy;
    logic [2:0]            req_type = '0;
    logic [15:0]           byte_count = '0;
    logic                  end_input = 0;
    logic [31:0]           ack_number = '0;
    logic [15:0]           peer_window = '0;
    logic [31:0]           elapsed_ms = '0;
    logic                  result_valid, kind, syn_flag, fin_flag, is_retransmit, last;
    logic [31:0]           seq_number;
    logic [LEN_W-1:0]      payload_len;
    logic [OFF_W-1:0]      stream_offset;
    logic [15:0]           in_flight;
    logic [RETRY_W-1:0]    retx_count;
    int                    errors, pending;
    int                    stall_cycles = 0;
    logic [31:0]           sent_end = 0;

    tcp_sender_window_retransmit_core i_dut (.*);

    tswr_checker i_checker (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // track the wrapped end of the newest fresh segment to build acceptable acks
    always @(posedge clk)
    begin
        if (result_valid && kind == KIND_SEGMENT && !is_retransmit && payload_len + syn_flag + fin_flag != 0)
            sent_end <= seq_number + payload_len + syn_flag + fin_flag;
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic issue_cmd(logic [2:0] op, logic [15:0] cnt, logic fin_in,
                             logic [31:0] ackn, logic [15:0] win, logic [31:0] ms);
        start <= 1;
        req_type <= op;
        byte_count <= cnt;
        end_input <= fin_in;
        ack_number <= ackn;
        peer_window <= win;
        elapsed_ms <= ms;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task automatic hold_off(int cycles);
        start <= 0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // drain all results, let the block settle, then load new settings
    task automatic reconfigure(logic [31:0] cap, logic [31:0] rto_ms, logic [31:0] isn_val);
        start <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_RTO, rto_ms);
        write_reg(CFG_ISN, isn_val);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_ms();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 50);
            1: return $urandom_range(500, 3000);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3000));
            1: return 16'hFFFF;
            2: return 0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_window();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 3000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_cmd(logic allow_end);
        int sel;
        logic [31:0] ackn;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            issue_cmd(REQ_WRITE, pick_count(), allow_end && $urandom_range(0, 7) == 0,
                      $urandom, 16'($urandom), $urandom);
        else if (sel < 50)
            issue_cmd(REQ_FILL, 16'($urandom), 1'($urandom), $urandom, 16'($urandom),
                      $urandom);
        else if (sel < 75)
        begin
            // mostly acks that cover some or all sent data
            case ($urandom_range(0, 3))
                0, 1: ackn = sent_end;
                2: ackn = sent_end - $urandom_range(0, 2000);
                default: ackn = $urandom;
            endcase
            issue_cmd(REQ_ACK, 16'($urandom), 1'($urandom), ackn, pick_window(), $urandom);
        end
        else if (sel < 90)
            issue_cmd(REQ_TICK, 16'($urandom), 1'($urandom), $urandom, 16'($urandom),
                      pick_ms());
        else if (sel < 95)
            issue_cmd(REQ_EMPTY, 16'($urandom), 1'($urandom), $urandom, 16'($urandom),
                      $urandom);
        else
            issue_cmd(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom), $urandom,
                      16'($urandom), $urandom);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: SYN, timer, ack, full window, zero window, bad acks, unknown ops
        issue_cmd(REQ_EMPTY, 0, 0, 0, 0, 0);
        issue_cmd(REQ_TICK, 0, 0, 0, 0, 100);
        issue_cmd(REQ_FILL, 0, 0, 0, 0, 0);
        issue_cmd(REQ_FILL, 0, 0, 0, 0, 0);
        issue_cmd(REQ_TICK, 0, 0, 0, 0, 0);
        issue_cmd(REQ_TICK, 0, 0, 0, 0, 1000);
        issue_cmd(REQ_ACK, 0, 0, sent_end, 16'hFFFF, 0);
        issue_cmd(REQ_WRITE, 16'hFFFF, 0, 0, 0, 0);
        issue_cmd(REQ_WRITE, 0, 0, 0, 0, 0);
        issue_cmd(REQ_WRITE, 1, 0, 0, 0, 0);
        issue_cmd(REQ_FILL, 0, 0, 0, 0, 0);
        issue_cmd(REQ_ACK, 0, 0, sent_end - 100, 0, 0);
        issue_cmd(REQ_FILL, 0, 0, 0, 0, 0);
        issue_cmd(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        issue_cmd(REQ_ACK, 0, 0, 0, 16'hFFFF, 0);
        issue_cmd(REQ_ACK, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 0);
        issue_cmd(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        issue_cmd(REQ_ACK, 0, 0, sent_end, 16'hFFFF, 0);
        issue_cmd(REQ_FILL, 0, 0, 0, 0, 0);
        issue_cmd(3'd5, 0, 0, 0, 0, 0);
        issue_cmd(3'd6, 0, 0, 0, 0, 0);
        issue_cmd(3'd7, 0, 0, 0, 0, 0);

        // random phases under different settings; the stream closes only in the last
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: reconfigure(1, 1, 32'hFFFF_FFFF);
                1: reconfigure(20'hFFFFF, 16'hFFFF, 0);
                2: reconfigure(4000, 30, 32'hFFFF_F000);
                default: reconfigure($urandom_range(1, 20'hFFFFF), $urandom_range(1, 16'hFFFF),
                                     $urandom);
            endcase
            for (int n = 0; n < 60; n++)
            begin
                if (phase < 5 && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 5));
                random_cmd(phase == 5);
            end
        end
        issue_cmd(REQ_WRITE, 16'hFFFF, 1, 0, 0, 0);
        issue_cmd(REQ_FILL, 0, 0, 0, 0, 0);

        start <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
